FILE: hdl/fde_pkg.sv
// Package with the item types and character constants of the FASTA encoder.
`default_nettype none

package fde_pkg;

  typedef struct packed {
    logic       operation;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic        residue_valid;
    logic [2:0]  base_code;
    logic        record_end;
    logic        not_dna;
    logic        empty_header;
    logic [31:0] residue_count;
    logic [31:0] bad_total;
  } out_item_t;

  typedef struct packed {
    logic      valid;
    out_item_t item;
  } result_t;

  localparam logic       OP_DATA = 1'b0;
  localparam logic       OP_EOF  = 1'b1;

  localparam logic [7:0] CHAR_GT    = 8'h3E;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_A     = 8'h41;
  localparam logic [7:0] CHAR_C     = 8'h43;
  localparam logic [7:0] CHAR_G     = 8'h47;
  localparam logic [7:0] CHAR_T     = 8'h54;
  localparam logic [7:0] CHAR_LO_A  = 8'h61;
  localparam logic [7:0] CHAR_LO_Z  = 8'h7A;
  localparam logic [7:0] CASE_BIT   = 8'h20;

  localparam logic [2:0] CODE_A   = 3'd0;
  localparam logic [2:0] CODE_C   = 3'd1;
  localparam logic [2:0] CODE_G   = 3'd2;
  localparam logic [2:0] CODE_T   = 3'd3;
  localparam logic [2:0] CODE_BAD = 3'd4;

  localparam logic [9:0] WINDOW_RESET = 10'd100;
  localparam logic [9:0] WINDOW_BAD_MAX = 10'h3FF;

  function automatic logic is_space(input logic [7:0] b);
    return ((b >= CHAR_TAB) && (b <= CHAR_CR)) || (b == CHAR_SPACE);
  endfunction

  function automatic logic [2:0] encode_base(input logic [7:0] b);
    logic [7:0] u;
    logic [2:0] code;
    u = ((b >= CHAR_LO_A) && (b <= CHAR_LO_Z)) ? (b - CASE_BIT) : b;
    unique case (u)
      CHAR_A:  code = CODE_A;
      CHAR_C:  code = CODE_C;
      CHAR_G:  code = CODE_G;
      CHAR_T:  code = CODE_T;
      default: code = CODE_BAD;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/fde_in_stage.sv
// Input register stage that holds one accepted byte item for the parser.
`default_nettype none

module fde_in_stage (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire fde_pkg::in_item_t in_data_i,
  input  wire logic             down_free_i,
  output logic                  advance_o,
  output fde_pkg::in_item_t     item_o
);

  logic              valid_q, valid_d;
  fde_pkg::in_item_t item_q;
  logic              fire;

  assign advance_o  = valid_q && down_free_i;
  assign in_ready_o = !valid_q || down_free_i;
  assign fire       = in_valid_i && in_ready_o;
  assign item_o     = item_q;

  always_comb begin
    valid_d = valid_q;
    if (fire) begin
      valid_d = 1'b1;
    end else if (advance_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      item_q <= in_data_i;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/fde_parser.sv
// Parser state and per-byte result logic of the FASTA encoder.
`default_nettype none

module fde_parser #(
  parameter int COUNTER_BITS = 32
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              advance_i,
  input  wire fde_pkg::in_item_t item_i,
  input  wire logic [9:0]        test_window_i,
  output fde_pkg::result_t       result_o
);

  localparam int XW = (COUNTER_BITS > 32) ? COUNTER_BITS : 33;

  localparam logic [1:0] MODE_PREAMBLE = 2'd0;
  localparam logic [1:0] MODE_HEADER   = 2'd1;
  localparam logic [1:0] MODE_SEQUENCE = 2'd2;

  logic [1:0]              mode_q, mode_d;
  logic                    hdr_ne_q, hdr_ne_d;
  logic [COUNTER_BITS-1:0] rr_q, rr_d;
  logic [9:0]              wb_q, wb_d;
  logic                    done_q, done_d;
  logic                    fail_q, fail_d;
  logic [COUNTER_BITS-1:0] bad_q, bad_d;

  logic [COUNTER_BITS-1:0] win_ext;
  logic                    rr_below;
  logic [9:0]              tested;
  logic                    close_fail;
  logic [2:0]              code;
  fde_pkg::result_t        res;

  function automatic logic [COUNTER_BITS-1:0] sat_inc(input logic [COUNTER_BITS-1:0] v);
    return (v == '1) ? v : v + COUNTER_BITS'(1);
  endfunction

  function automatic logic [31:0] sat32(input logic [COUNTER_BITS-1:0] v);
    logic [XW-1:0] x;
    x = XW'(v);
    return (x > XW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : x[31:0];
  endfunction

  assign win_ext    = COUNTER_BITS'(test_window_i);
  assign rr_below   = rr_q < win_ext;
  assign tested     = rr_below ? rr_q[9:0] : test_window_i;
  assign close_fail = done_q ? fail_q : ({wb_q, 1'b0} > {1'b0, tested});
  assign code       = fde_pkg::encode_base(item_i.data_byte);
  assign result_o   = res;

  always_comb begin
    mode_d   = mode_q;
    hdr_ne_d = hdr_ne_q;
    rr_d     = rr_q;
    wb_d     = wb_q;
    done_d   = done_q;
    fail_d   = fail_q;
    bad_d    = bad_q;
    res      = '0;

    if (item_i.operation == fde_pkg::OP_EOF) begin
      if ((mode_q == MODE_HEADER) || (mode_q == MODE_SEQUENCE)) begin
        res.valid             = 1'b1;
        res.item.record_end   = 1'b1;
        res.item.not_dna      = close_fail;
        res.item.empty_header = !hdr_ne_q;
        res.item.residue_count = sat32(rr_q);
        res.item.bad_total    = sat32(bad_q);
        done_d                = 1'b1;
        fail_d                = close_fail;
      end
      mode_d = MODE_PREAMBLE;
    end else begin
      unique case (mode_q)
        MODE_PREAMBLE: begin
          if (item_i.data_byte == fde_pkg::CHAR_GT) begin
            mode_d   = MODE_HEADER;
            hdr_ne_d = 1'b0;
            rr_d     = '0;
            wb_d     = '0;
            done_d   = 1'b0;
            fail_d   = 1'b0;
          end
        end
        MODE_HEADER: begin
          if (item_i.data_byte == fde_pkg::CHAR_LF) begin
            mode_d = MODE_SEQUENCE;
          end else begin
            hdr_ne_d = 1'b1;
          end
        end
        MODE_SEQUENCE: begin
          if (item_i.data_byte == fde_pkg::CHAR_GT) begin
            res.valid              = 1'b1;
            res.item.record_end    = 1'b1;
            res.item.not_dna       = close_fail;
            res.item.empty_header  = !hdr_ne_q;
            res.item.residue_count = sat32(rr_q);
            res.item.bad_total     = sat32(bad_q);
            mode_d   = MODE_HEADER;
            hdr_ne_d = 1'b0;
            rr_d     = '0;
            wb_d     = '0;
            done_d   = 1'b0;
            fail_d   = 1'b0;
          end else if (!fde_pkg::is_space(item_i.data_byte)) begin
            if (code == fde_pkg::CODE_BAD) begin
              bad_d = sat_inc(bad_q);
              if (rr_below && (wb_q != fde_pkg::WINDOW_BAD_MAX)) begin
                wb_d = wb_q + 10'd1;
              end
            end
            rr_d = sat_inc(rr_q);
            if (!done_q && (rr_d >= win_ext)) begin
              done_d = 1'b1;
              fail_d = {wb_d, 1'b0} > {1'b0, test_window_i};
            end
            res.valid              = 1'b1;
            res.item.residue_valid = 1'b1;
            res.item.base_code     = code;
            res.item.not_dna       = fail_d;
            res.item.empty_header  = !hdr_ne_q;
            res.item.residue_count = sat32(rr_d);
            res.item.bad_total     = sat32(bad_d);
          end
        end
        default: begin
          mode_d = MODE_PREAMBLE;
        end
      endcase
    end

    if (!advance_i) begin
      res.valid = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_PREAMBLE;
      hdr_ne_q <= 1'b0;
      rr_q     <= '0;
      wb_q     <= '0;
      done_q   <= 1'b0;
      fail_q   <= 1'b0;
      bad_q    <= '0;
    end else if (advance_i) begin
      mode_q   <= mode_d;
      hdr_ne_q <= hdr_ne_d;
      rr_q     <= rr_d;
      wb_q     <= wb_d;
      done_q   <= done_d;
      fail_q   <= fail_d;
      bad_q    <= bad_d;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/fde_out_stage.sv
// Output register stage that holds one result until the consumer takes it.
`default_nettype none

module fde_out_stage (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire fde_pkg::result_t result_i,
  output logic                  free_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output fde_pkg::out_item_t    out_data_o
);

  logic               valid_q;
  fde_pkg::out_item_t item_q;

  assign free_o      = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= result_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && result_i.valid) begin
      item_q <= result_i.item;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/fasta_dna_2bit_encoder.sv
// Top level of the FASTA byte stream to 2-bit nucleotide encoder.
//
//   Channel | Direction | Handshake                       | Payload
//   input   | in        | in_valid_i / in_ready_o         | in_data_i (in_item_t)
//   output  | out       | out_valid_o / out_ready_i       | out_data_o (out_item_t)
//   config  | in        | cfg_we_i                        | cfg_data_i (test window)
//
// One byte item is taken per cycle while in_ready_o is high; results pass both registers.
// The throughput is set by the single parser step between input and output registers.
// Reset clears the parser to the preamble state and loads a test window of 100.
// A stalled output only holds the pipeline when both registers are full.
`default_nettype none

module fasta_dna_2bit_encoder #(
  parameter int COUNTER_BITS = 32
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire fde_pkg::in_item_t in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output fde_pkg::out_item_t     out_data_o,
  input  wire logic              cfg_we_i,
  input  wire logic [9:0]        cfg_data_i
);

  logic              [9:0] test_window_q;
  logic              down_free;
  logic              advance;
  fde_pkg::in_item_t item;
  fde_pkg::result_t  result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      test_window_q <= fde_pkg::WINDOW_RESET;
    end else if (cfg_we_i) begin
      test_window_q <= cfg_data_i;
    end
  end

  fde_in_stage u_in (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .down_free_i (down_free),
    .advance_o   (advance),
    .item_o      (item)
  );

  fde_parser #(
    .COUNTER_BITS (COUNTER_BITS)
  ) u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .advance_i     (advance),
    .item_i        (item),
    .test_window_i (test_window_q),
    .result_o      (result)
  );

  fde_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .result_i    (result),
    .free_o      (down_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

FILE: hdl/fde_checker.sv
// Port-level checker for the FASTA encoder and its bind to the top level.
`default_nettype none

module fde_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire fde_pkg::out_item_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("Output changed while a transfer was pending.");

  a_end_or_residue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.residue_valid && out_data_o.record_end))
    else $error("Result is both a residue and a record end.");

  a_end_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.record_end |-> out_data_o.base_code == fde_pkg::CODE_A)
    else $error("Record end carries a nonzero base code.");

  a_bad_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.residue_valid && out_data_o.base_code == fde_pkg::CODE_BAD
      |-> out_data_o.bad_total != 32'd0 && out_data_o.residue_count != 32'd0)
    else $error("Bad residue was not counted.");

endmodule

bind fasta_dna_2bit_encoder fde_checker u_fde_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

FILE: tb/sv/fasta_stream_checker.sv
// Checker that predicts and compares the results of the FASTA nucleotide encoder.
`timescale 1ns / 100ps

module fasta_stream_checker #(
  parameter int COUNTER_BITS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  fde_pkg::in_item_t   in_data_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  fde_pkg::out_item_t  out_data_i,
  input  logic                cfg_we_i,
  input  logic [9:0]          cfg_data_i,
  output int                  fail_count_o,
  output int                  pending_o,
  output int                  residues_o,
  output int                  closes_o,
  output int                  not_dna_o,
  output int                  empty_hdr_o
);

  typedef enum logic [1:0] {
    PARSE_PREAMBLE,
    PARSE_HEADER,
    PARSE_SEQUENCE
  } parse_mode_e;

  localparam logic [COUNTER_BITS-1:0] CNT_MAX = '1;

  parse_mode_e             mode;
  logic [9:0]              window;
  logic                    hdr_text;
  logic [COUNTER_BITS-1:0] rec_residues;
  logic [9:0]              win_bad;
  logic                    decided;
  logic                    verdict_bad;
  logic [COUNTER_BITS-1:0] bad_cnt;
  fde_pkg::out_item_t      expected_q[$];
  fde_pkg::out_item_t      want;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    residues_o   = 0;
    closes_o     = 0;
    not_dna_o    = 0;
    empty_hdr_o  = 0;
  end

  task automatic report(string msg);
    $display("%0t ERROR %s", $time, msg);
    fail_count_o++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] exp_val);
    if (got !== exp_val) begin
      report($sformatf("%s: got %0d, expected %0d", name, got, exp_val));
    end
  endtask

  function automatic logic [31:0] clip32(logic [COUNTER_BITS-1:0] v);
    if (COUNTER_BITS > 32 && (v >> 32) != 0) return '1;
    return 32'(v);
  endfunction

  function automatic void judge();
    longint unsigned tested;
    tested = (rec_residues < window) ? rec_residues : window;
    verdict_bad = (64'(win_bad) << 1) > tested;
    decided = 1'b1;
  endfunction

  function automatic void push_result(logic has_residue, logic [2:0] code, logic closing);
    fde_pkg::out_item_t r;
    r.residue_valid = has_residue;
    r.base_code     = code;
    r.record_end    = closing;
    r.not_dna       = verdict_bad;
    r.empty_header  = !hdr_text;
    r.residue_count = clip32(rec_residues);
    r.bad_total     = clip32(bad_cnt);
    expected_q.insert(expected_q.size(), r);
  endfunction

  function automatic void open_record();
    mode         = PARSE_HEADER;
    hdr_text     = 1'b0;
    rec_residues = '0;
    win_bad      = '0;
    decided      = 1'b0;
    verdict_bad  = 1'b0;
  endfunction

  function automatic void close_record();
    if (!decided) judge();
    push_result(1'b0, fde_pkg::CODE_A, 1'b1);
  endfunction

  function automatic void predict(fde_pkg::in_item_t it);
    logic [7:0] ch;
    logic [2:0] code;
    ch = it.data_byte;
    if (it.operation == fde_pkg::OP_EOF) begin
      if (mode != PARSE_PREAMBLE) close_record();
      mode = PARSE_PREAMBLE;
      return;
    end
    case (mode)
      PARSE_PREAMBLE: begin
        if (ch == fde_pkg::CHAR_GT) open_record();
      end
      PARSE_HEADER: begin
        if (ch == fde_pkg::CHAR_LF) mode = PARSE_SEQUENCE;
        else hdr_text = 1'b1;
      end
      default: begin
        if (ch == fde_pkg::CHAR_GT) begin
          close_record();
          open_record();
        end else if (!((ch >= fde_pkg::CHAR_TAB && ch <= fde_pkg::CHAR_CR) ||
                       ch == fde_pkg::CHAR_SPACE)) begin
          if (ch >= fde_pkg::CHAR_LO_A && ch <= fde_pkg::CHAR_LO_Z) begin
            ch = ch - fde_pkg::CASE_BIT;
          end
          case (ch)
            fde_pkg::CHAR_A: code = fde_pkg::CODE_A;
            fde_pkg::CHAR_C: code = fde_pkg::CODE_C;
            fde_pkg::CHAR_G: code = fde_pkg::CODE_G;
            fde_pkg::CHAR_T: code = fde_pkg::CODE_T;
            default:         code = fde_pkg::CODE_BAD;
          endcase
          if (code == fde_pkg::CODE_BAD) begin
            if (bad_cnt != CNT_MAX) bad_cnt++;
            if (rec_residues < window && win_bad != fde_pkg::WINDOW_BAD_MAX) win_bad++;
          end
          if (rec_residues != CNT_MAX) rec_residues++;
          if (!decided && rec_residues >= window) judge();
          push_result(1'b1, code, 1'b0);
        end
      end
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window       = fde_pkg::WINDOW_RESET;
      mode         = PARSE_PREAMBLE;
      hdr_text     = 1'b0;
      rec_residues = '0;
      win_bad      = '0;
      decided      = 1'b0;
      verdict_bad  = 1'b0;
      bad_cnt      = '0;
      expected_q.delete();
      pending_o    = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          report("result transfer arrived with no result expected");
        end else begin
          want = expected_q.pop_front();
          check_field("residue_valid", out_data_i.residue_valid, want.residue_valid);
          check_field("base_code", out_data_i.base_code, want.base_code);
          check_field("record_end", out_data_i.record_end, want.record_end);
          check_field("not_dna", out_data_i.not_dna, want.not_dna);
          check_field("empty_header", out_data_i.empty_header, want.empty_header);
          check_field("residue_count", out_data_i.residue_count, want.residue_count);
          check_field("bad_total", out_data_i.bad_total, want.bad_total);
        end
        if (out_data_i.residue_valid) residues_o++;
        if (out_data_i.record_end) begin
          closes_o++;
          if (out_data_i.not_dna) not_dna_o++;
          if (out_data_i.empty_header) empty_hdr_o++;
        end
      end
      if (in_valid_i && in_ready_i) predict(in_data_i);
      if (cfg_we_i) window = cfg_data_i;
      pending_o = expected_q.size();
    end
  end

endmodule

FILE: tb/sv/tb_top.sv
// Testbench top that feeds FASTA byte streams to the encoder and gives the verdict.
`timescale 1ns / 100ps

module tb_top;

  localparam int RANDOM_ITEMS = 1325;
  localparam int NUM_PHASES   = 6;
  localparam int DRAIN_CYCLES = 4;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  fde_pkg::in_item_t  in_data_i   = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  fde_pkg::out_item_t out_data_o;
  logic               cfg_we_i    = 1'b0;
  logic [9:0]         cfg_data_i  = '0;

  int fail_count;
  int pending;
  int residues;
  int closes;
  int not_dna_records;
  int empty_hdr_records;
  int items_sent  = 0;
  int windows_set = 0;
  bit quiet       = 1'b0;

  logic [9:0] phase_window [NUM_PHASES] = '{10'd1, 10'd5, 10'd1023, 10'd16, 10'd100, 10'd7};

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  fasta_dna_2bit_encoder i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i)
  );

  fasta_stream_checker i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_i  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .residues_o  (residues),
    .closes_o    (closes),
    .not_dna_o   (not_dna_records),
    .empty_hdr_o (empty_hdr_records)
  );

  task automatic send(logic op, logic [7:0] b);
    fde_pkg::in_item_t it;
    it.operation = op;
    it.data_byte = b;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    items_sent++;
  endtask

  task automatic settle(int cycles);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (cycles) @(negedge clk_i);
  endtask

  task automatic set_window(logic [9:0] w);
    settle(DRAIN_CYCLES);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= w;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    windows_set++;
  endtask

  function automatic logic [7:0] bad_byte();
    logic [7:0] b;
    logic       ok;
    do begin
      b  = 8'($urandom_range(0, 255));
      ok = !((b >= fde_pkg::CHAR_TAB && b <= fde_pkg::CHAR_CR) ||
             b == fde_pkg::CHAR_SPACE || b == fde_pkg::CHAR_GT);
      case (b & ~fde_pkg::CASE_BIT)
        fde_pkg::CHAR_A, fde_pkg::CHAR_C, fde_pkg::CHAR_G, fde_pkg::CHAR_T: ok = 1'b0;
        default: ;
      endcase
    end while (!ok);
    return b;
  endfunction

  task automatic send_record();
    string      bases = "ACGTacgt";
    int         len;
    int         bad_pct;
    logic [7:0] b;
    send(fde_pkg::OP_DATA, fde_pkg::CHAR_GT);
    if ($urandom_range(0, 3) != 0) begin
      repeat ($urandom_range(1, 8)) begin
        do b = 8'($urandom_range(0, 255)); while (b == fde_pkg::CHAR_LF);
        send(fde_pkg::OP_DATA, b);
      end
    end
    if ($urandom_range(0, 15) == 0) begin
      send(fde_pkg::OP_EOF, 8'($urandom_range(0, 255)));
      return;
    end
    send(fde_pkg::OP_DATA, fde_pkg::CHAR_LF);
    len = ($urandom_range(0, 19) == 0) ? $urandom_range(95, 140) : $urandom_range(0, 40);
    case ($urandom_range(0, 4))
      0, 1:    bad_pct = 0;
      2:       bad_pct = 20;
      3:       bad_pct = 50;
      default: bad_pct = 90;
    endcase
    repeat (len) begin
      if ($urandom_range(0, 7) == 0) begin
        if ($urandom_range(0, 5) == 0) send(fde_pkg::OP_DATA, fde_pkg::CHAR_SPACE);
        else send(fde_pkg::OP_DATA, 8'($urandom_range(fde_pkg::CHAR_TAB, fde_pkg::CHAR_CR)));
      end
      if ($urandom_range(1, 100) <= bad_pct) send(fde_pkg::OP_DATA, bad_byte());
      else send(fde_pkg::OP_DATA, bases[$urandom_range(0, 7)]);
    end
  endtask

  task automatic send_chunk();
    case ($urandom_range(0, 15))
      0: send(fde_pkg::OP_EOF, 8'($urandom_range(0, 255)));
      1: repeat ($urandom_range(1, 6)) send(fde_pkg::OP_DATA, 8'($urandom_range(0, 255)));
      2: begin
        send(fde_pkg::OP_EOF, 8'($urandom_range(0, 255)));
        repeat ($urandom_range(1, 4)) send(fde_pkg::OP_DATA, bad_byte());
      end
      default: send_record();
    endcase
  endtask

  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!quiet && $urandom_range(0, 9) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int phase_end;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    set_window(10'd3);
    send(fde_pkg::OP_EOF, 8'hFF);
    send(fde_pkg::OP_DATA, 8'h00);
    send(fde_pkg::OP_DATA, fde_pkg::CHAR_GT);
    send(fde_pkg::OP_DATA, fde_pkg::CHAR_LF);
    send(fde_pkg::OP_DATA, fde_pkg::CHAR_A);
    send(fde_pkg::OP_DATA, "c");
    send(fde_pkg::OP_DATA, "g");
    send(fde_pkg::OP_DATA, fde_pkg::CHAR_T);
    send(fde_pkg::OP_DATA, fde_pkg::CHAR_SPACE);
    send(fde_pkg::OP_DATA, fde_pkg::CHAR_CR);
    send(fde_pkg::OP_DATA, "n");
    send(fde_pkg::OP_DATA, 8'hFF);
    send(fde_pkg::OP_DATA, fde_pkg::CHAR_GT);
    send(fde_pkg::OP_DATA, fde_pkg::CHAR_GT);
    send(fde_pkg::OP_EOF, 8'h00);

    set_window(10'd0);
    send(fde_pkg::OP_DATA, fde_pkg::CHAR_GT);
    send(fde_pkg::OP_DATA, fde_pkg::CHAR_LF);
    send(fde_pkg::OP_DATA, "N");
    send(fde_pkg::OP_EOF, 8'h5A);

    set_window(10'd1023);
    send(fde_pkg::OP_DATA, fde_pkg::CHAR_GT);
    send(fde_pkg::OP_DATA, fde_pkg::CHAR_LF);
    send(fde_pkg::OP_DATA, "N");
    set_window(10'd2);
    send(fde_pkg::OP_DATA, "N");
    send(fde_pkg::OP_DATA, fde_pkg::CHAR_A);
    send(fde_pkg::OP_EOF, 8'hA5);

    phase_window[3] = 10'($urandom_range(2, 30));
    for (int p = 0; p < NUM_PHASES; p++) begin
      set_window(phase_window[p]);
      quiet     = (p == NUM_PHASES - 1);
      phase_end = items_sent + RANDOM_ITEMS / NUM_PHASES;
      while (items_sent < phase_end) send_chunk();
    end
    send(fde_pkg::OP_EOF, 8'h00);
    settle(10);

    $display("Sent %0d byte and end-of-file transfers under %0d test window settings.",
             items_sent, windows_set);
    $display("Checked %0d residues and %0d record closes (%0d not DNA, %0d empty header).",
             residues, closes, not_dna_records, empty_hdr_records);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
